// ===== rtl/core/deq_pkg.sv =====
// shared types and codes for the double-ended queue
package deq_pkg;

  localparam int unsigned DEQ_CAPACITY = 16;
  localparam int unsigned DEQ_DATA_W   = 32;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_LIST_FWD   = 3'd4,
    KIND_LIST_BWD   = 3'd5
  } deq_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } deq_status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_RIGHT,
    CELL_SHIFT_LEFT,
    CELL_LOAD_BACK,
    CELL_ROT_LEFT,
    CELL_ROT_RIGHT
  } deq_cell_op_e;

  typedef struct packed {
    deq_cell_op_e op;
    logic         in_use;
    logic         is_tail;
    logic         is_next;
  } deq_cell_ctl_t;

  typedef struct packed {
    logic [2:0]                   kind;
    logic signed [DEQ_DATA_W-1:0] value;
  } deq_req_t;

  typedef struct packed {
    logic signed [DEQ_DATA_W-1:0] value_res;
    logic [1:0]                   status;
    logic                         last;
  } deq_res_t;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// top level of the double-ended queue
//
// requests arrive on req_valid_i / req_stall_o with a kind and a value;
// results leave on res_valid_o / res_stall_i with value, status and last.
// entries live in a row of cells, cell 0 holding the front; front pushes and
// pops shift the row, a back push fills the next free cell. a push or pop is
// taken every cycle while the result register drains, and its single result
// appears in the cycle after the request. a listing of n entries enters the
// listing state, then rotates the row once per cycle while the result
// register drains, giving n results and leaving the row as it was.
// requests stall throughout a listing. an empty listing, a pop when empty
// and a push when full give one status result. unused kinds are taken and
// give no result. when the receiver stalls, the result register holds and
// requests stall. reset empties the queue and clears the result register;
// it needs no clearing pass.
module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned CAPACITY = DEQ_CAPACITY
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_stall_o,
  input  deq_req_t req_i,
  output logic     res_valid_o,
  input  logic     res_stall_i,
  output deq_res_t res_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic {ST_IDLE, ST_LIST} state_e;

  state_e        state_q;
  logic          dir_bwd_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] rem_q;
  logic          res_valid_q;
  deq_res_t      res_q;

  logic signed [DEQ_DATA_W-1:0] cell_val [CAPACITY];
  deq_cell_ctl_t                cell_ctl [CAPACITY];
  logic signed [DEQ_DATA_W-1:0] head_val, tail_val, left0_val;
  deq_cell_op_e                 op;
  logic                         out_free, accept, full, empty;

  assign out_free    = !res_valid_q || !res_stall_i;
  assign req_stall_o = (state_q == ST_LIST) || !out_free;
  assign accept      = req_valid_i && !req_stall_o;
  assign full        = (count_q == CW'(CAPACITY));
  assign empty       = (count_q == '0);
  assign head_val    = cell_val[0];

  always_comb begin
    tail_val = '0;
    for (int k = 0; k < int'(CAPACITY); k++) begin
      if (cell_ctl[k].is_tail) tail_val = tail_val | cell_val[k];
    end
  end

  always_comb begin
    op = CELL_HOLD;
    if (accept) begin
      case (req_i.kind)
        KIND_PUSH_FRONT: if (!full)  op = CELL_SHIFT_RIGHT;
        KIND_PUSH_BACK:  if (!full)  op = CELL_LOAD_BACK;
        KIND_POP_FRONT:  if (!empty) op = CELL_SHIFT_LEFT;
        default:         op = CELL_HOLD;
      endcase
    end else if (state_q == ST_LIST && out_free) begin
      op = dir_bwd_q ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
    end
  end

  assign left0_val = (op == CELL_ROT_RIGHT) ? tail_val : req_i.value;

  for (genvar i = 0; i < int'(CAPACITY); i++) begin : g_cell
    logic signed [DEQ_DATA_W-1:0] left_v, right_v;

    assign cell_ctl[i].op      = op;
    assign cell_ctl[i].in_use  = (CW'(i) < count_q);
    assign cell_ctl[i].is_tail = (CW'(i + 1) == count_q);
    assign cell_ctl[i].is_next = (CW'(i) == count_q);

    if (i == 0) begin : g_first
      assign left_v = left0_val;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end

    if (i == int'(CAPACITY) - 1) begin : g_last
      assign right_v = head_val;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    deq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[i]),
      .left_i  (left_v),
      .right_i (right_v),
      .head_i  (head_val),
      .push_i  (req_i.value),
      .value_o (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_bwd_q   <= 1'b0;
      count_q     <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else if (accept) begin
      res_valid_q     <= 1'b1;
      res_q.value_res <= '0;
      res_q.status    <= STATUS_OK;
      res_q.last      <= 1'b1;
      case (req_i.kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (full) begin
            res_q.status <= STATUS_FULL;
          end else begin
            count_q <= count_q + CW'(1);
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (empty) begin
            res_q.status <= STATUS_EMPTY;
          end else begin
            res_q.value_res <= (req_i.kind == KIND_POP_FRONT) ? head_val : tail_val;
            count_q         <= count_q - CW'(1);
          end
        end
        KIND_LIST_FWD, KIND_LIST_BWD: begin
          if (empty) begin
            res_q.status <= STATUS_EMPTY;
          end else begin
            res_valid_q <= 1'b0;
            state_q     <= ST_LIST;
            dir_bwd_q   <= (req_i.kind == KIND_LIST_BWD);
            rem_q       <= count_q;
          end
        end
        default: res_valid_q <= 1'b0;
      endcase
    end else if (state_q == ST_LIST && out_free) begin
      res_valid_q     <= 1'b1;
      res_q.value_res <= dir_bwd_q ? tail_val : head_val;
      res_q.status    <= STATUS_OK;
      res_q.last      <= (rem_q == CW'(1));
      rem_q           <= rem_q - CW'(1);
      if (rem_q == CW'(1)) state_q <= ST_IDLE;
    end else if (out_free) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/deq_cell.sv =====
// one storage cell of the queue chain
module deq_cell import deq_pkg::*; (
  input  logic                         clk_i,
  input  deq_cell_ctl_t                ctl_i,
  input  logic signed [DEQ_DATA_W-1:0] left_i,
  input  logic signed [DEQ_DATA_W-1:0] right_i,
  input  logic signed [DEQ_DATA_W-1:0] head_i,
  input  logic signed [DEQ_DATA_W-1:0] push_i,
  output logic signed [DEQ_DATA_W-1:0] value_o
);

  logic signed [DEQ_DATA_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (ctl_i.op)
      CELL_SHIFT_RIGHT: value_d = left_i;
      CELL_SHIFT_LEFT:  value_d = right_i;
      CELL_LOAD_BACK: begin
        if (ctl_i.is_next) value_d = push_i;
      end
      CELL_ROT_LEFT: begin
        if (ctl_i.is_tail) begin
          value_d = head_i;
        end else if (ctl_i.in_use) begin
          value_d = right_i;
        end
      end
      CELL_ROT_RIGHT: begin
        if (ctl_i.in_use) value_d = left_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
